### sv/flg_pkg.sv
// ============================================================================
// flg_pkg
// Shared constants, types and helpers for the audio flanger.
// ============================================================================
`default_nettype none

package flg_pkg;

   localparam int SAMPLE_BITS     = 24;
   localparam int RING_DEPTH_DEF  = 4096;
   localparam int SINE_SIZE_DEF   = 1024;

   localparam int PHASE_W         = 32;
   localparam int FRAC_W          = 8;
   localparam int DEPTH_W         = 20;
   localparam int STEP_W          = 24;
   localparam int FBK_W           = 16;
   localparam int WET_W           = 17;
   localparam int CSR_ADDR_W      = 2;
   localparam int CSR_DATA_W      = 24;
   localparam int SAT_IN_W        = 27;

   // quarter-wave sine polynomial coefficients
   localparam logic [11:0] SIN_C  = 12'd2320;
   localparam logic [14:0] SIN_B  = 15'd21024;
   localparam logic [15:0] SIN_A  = 16'd51472;

   localparam logic [16:0] Z_ONE      = 17'd32768;
   localparam logic [16:0] GAIN_UNITY = 17'd65536;
   localparam logic [16:0] WET_RESET  = 17'd32768;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DEPTH = 2'd0,
      CSR_STEP  = 2'd1,
      CSR_FBK   = 2'd2,
      CSR_WET   = 2'd3
   } csr_addr_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_Z2,
      ST_R1,
      ST_R2,
      ST_Y,
      ST_DELAY,
      ST_READA,
      ST_READB,
      ST_INTERP,
      ST_FEEDBK,
      ST_STORE,
      ST_MIX
   } state_type;

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [SAT_IN_W-1:0] val
   );
      logic signed [SAT_IN_W-1:0] hi;
      logic signed [SAT_IN_W-1:0] lo;
      hi = SAT_IN_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
      lo = -hi - SAT_IN_W'(1);
      if (val > hi) begin
         sat_sample = hi[SAMPLE_BITS-1:0];
      end else if (val < lo) begin
         sat_sample = lo[SAMPLE_BITS-1:0];
      end else begin
         sat_sample = val[SAMPLE_BITS-1:0];
      end
   endfunction

endpackage

`default_nettype wire

### sv/flg_ram.sv
// ============================================================================
// flg_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
`default_nettype none

module flg_ram #(
   parameter int DATA_W = 24,
   parameter int DEPTH  = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/audio_flanger.sv
// ============================================================================
// audio_flanger
// Mono flanger with feedback and a sine LFO over a power-of-two delay ring.
// ============================================================================
// Each sample is worked through a sequence of states from input transfer to result: the sine
// polynomial runs as a chain of four registered multiplies, and the two ring
// taps are fetched one after the other through the single read port of the
// ring memory before the new entry is written back. One sample is processed
// at a time; the next input transfer is taken while a finished result waits
// in the output register. After reset the ring is cleared one entry per
// cycle, all RING_DEPTH entries (4096 by default), and no input transfer is
// taken until that pass ends; configuration writes are taken at any time.
// ============================================================================
`default_nettype none

module audio_flanger
   import flg_pkg::*;
#(
   parameter int RING_DEPTH      = RING_DEPTH_DEF,
   parameter int SINE_TABLE_SIZE = SINE_SIZE_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [23:0]            req_tdata,   // [23:0] in_sample
   // result channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [23:0]                 rsp_tdata,   // [23:0] out_sample
   // configuration
   input  wire logic                   csr_we,
   input  wire logic [CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW     = $clog2(RING_DEPTH);
   localparam int POS_W  = AW + FRAC_W;
   localparam int TB     = $clog2(SINE_TABLE_SIZE);
   localparam int DLY_W  = 22;
   localparam int CMP_W  = POS_W + DEPTH_W;
   localparam logic [PHASE_W-1:0] PH_MASK =
      ~((PHASE_W'(1) << (PHASE_W - TB)) - PHASE_W'(1));
   localparam logic [CMP_W-1:0] POS_MAX = {{DEPTH_W{1'b0}}, {POS_W{1'b1}}};

   // control state
   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [AW-1:0]        wi_ff, wi_in;
   logic [PHASE_W-1:0]   lfo_phase_ff, lfo_phase_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;

   // configuration registers
   logic [DEPTH_W-1:0]   depth_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [FBK_W-1:0]     fbk_ff;
   logic [WET_W-1:0]     wet_ff;

   // datapath registers
   logic signed [23:0]   x_ff, x_in;
   logic [1:0]           quad_ff, quad_in;
   logic [16:0]          z_ff, z_in;
   logic [16:0]          z2_ff, z2_in;
   logic [14:0]          r1_ff, r1_in;
   logic [15:0]          r2_ff, r2_in;
   logic [16:0]          y_ff, y_in;
   logic [DLY_W-1:0]     delay_ff, delay_in;
   logic [AW-1:0]        ib_ff, ib_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic signed [33:0]   acc_ff, acc_in;
   logic signed [23:0]   dly_ff, dly_in;
   logic signed [40:0]   fbp_ff, fbp_in;
   logic signed [41:0]   dry_ff, dry_in;
   logic [23:0]          rsp_tdata_ff, rsp_tdata_in;

   // combinational helpers
   logic                 out_free;
   logic [PHASE_W-1:0]   phase_q;
   logic [16:0]          z_raw;
   logic [33:0]          z_sq;
   logic [28:0]          c_prod;
   logic [31:0]          r1_prod;
   logic [32:0]          y_prod;
   logic [17:0]          lfo_uni;
   logic [DEPTH_W-1:0]   depth_c;
   logic [37:0]          dly_prod;
   logic [CMP_W-1:0]     rp_diff;
   logic [AW-1:0]        ia;
   logic [8:0]           frac_inv;
   logic signed [23:0]   ram_smp;
   logic signed [33:0]   a_prod;
   logic signed [32:0]   b_prod;
   logic signed [34:0]   interp_rnd;
   logic signed [40:0]   fb_rnd;
   logic signed [SAT_IN_W-1:0] store_sum;
   logic signed [23:0]   stored;
   logic [WET_W-1:0]     wet_c;
   logic [WET_W-1:0]     dry_w;
   logic signed [41:0]   wet_prod;
   logic signed [42:0]   mix_rnd;
   logic signed [23:0]   mixed;

   // ring memory ports
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [23:0]          ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [23:0]          ram_rdata;

   flg_ram #(
      .DATA_W (SAMPLE_BITS),
      .DEPTH  (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // arithmetic shared by the sequencer
   always_comb begin
      phase_q   = lfo_phase_ff & PH_MASK;
      z_raw     = {2'b00, phase_q[29:15]};
      z_sq      = z_ff * z_ff;
      c_prod    = SIN_C * z2_ff;
      r1_prod   = r1_ff * z2_ff;
      y_prod    = r2_ff * z_ff;
      lfo_uni   = quad_ff[1] ? ({1'b0, Z_ONE} - {1'b0, y_ff})
                             : ({1'b0, Z_ONE} + {1'b0, y_ff});
      depth_c   = ({{POS_W{1'b0}}, depth_ff} > POS_MAX) ? POS_MAX[DEPTH_W-1:0]
                                                        : depth_ff;
      dly_prod  = depth_c * lfo_uni;
      rp_diff   = {{DEPTH_W{1'b0}}, wi_ff, {FRAC_W{1'b0}}}
                - {{(CMP_W - DLY_W){1'b0}}, delay_ff};
      ia        = rp_diff[POS_W-1:FRAC_W];
      frac_inv  = 9'd256 - {1'b0, frac_ff};
      ram_smp   = $signed(ram_rdata);
      a_prod    = ram_smp * $signed({1'b0, frac_inv});
      b_prod    = ram_smp * $signed({1'b0, frac_ff});
      interp_rnd = 35'(acc_ff) + 35'(b_prod) + 35'sd128;
      fb_rnd    = fbp_ff + 41'sd32768;
      store_sum = SAT_IN_W'(x_ff) + SAT_IN_W'($signed(fb_rnd[40:16]));
      stored    = sat_sample(store_sum);
      wet_c     = (wet_ff > GAIN_UNITY) ? GAIN_UNITY : wet_ff;
      dry_w     = GAIN_UNITY - wet_c;
      wet_prod  = $signed({1'b0, wet_c}) * dly_ff;
      mix_rnd   = 43'(dry_ff) + 43'(wet_prod) + 43'sd32768;
      mixed     = sat_sample(mix_rnd[42:16]);
   end

   // sequencer: next state, datapath next values and memory control
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      wi_in         = wi_ff;
      lfo_phase_in  = lfo_phase_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      x_in          = x_ff;
      quad_in       = quad_ff;
      z_in          = z_ff;
      z2_in         = z2_ff;
      r1_in         = r1_ff;
      r2_in         = r2_ff;
      y_in          = y_ff;
      delay_in      = delay_ff;
      ib_in         = ib_ff;
      frac_in       = frac_ff;
      acc_in        = acc_ff;
      dly_in        = dly_ff;
      fbp_in        = fbp_ff;
      dry_in        = dry_ff;
      ram_we        = 1'b0;
      ram_waddr     = wi_ff;
      ram_wdata     = stored;
      ram_raddr     = ia;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in         = $signed(req_tdata);
               quad_in      = phase_q[31:30];
               z_in         = phase_q[30] ? (Z_ONE - z_raw) : z_raw;
               lfo_phase_in = lfo_phase_ff + {{(PHASE_W - STEP_W){1'b0}}, step_ff};
               state_in     = ST_Z2;
            end
         end
         ST_Z2: begin
            z2_in    = z_sq[31:15];
            state_in = ST_R1;
         end
         ST_R1: begin
            r1_in    = SIN_B - {1'b0, c_prod[28:15]};
            state_in = ST_R2;
         end
         ST_R2: begin
            r2_in    = SIN_A - r1_prod[30:15];
            state_in = ST_Y;
         end
         ST_Y: begin
            y_in     = y_prod[31:15];
            state_in = ST_DELAY;
         end
         ST_DELAY: begin
            delay_in = dly_prod[37:16];
            state_in = ST_READA;
         end
         ST_READA: begin
            ram_raddr = ia;
            ib_in     = ia + 1'b1;
            frac_in   = rp_diff[FRAC_W-1:0];
            state_in  = ST_READB;
         end
         ST_READB: begin
            ram_raddr = ib_ff;
            acc_in    = a_prod;
            state_in  = ST_INTERP;
         end
         ST_INTERP: begin
            dly_in   = interp_rnd[31:8];
            state_in = ST_FEEDBK;
         end
         ST_FEEDBK: begin
            fbp_in   = $signed({1'b0, fbk_ff}) * dly_ff;
            state_in = ST_STORE;
         end
         ST_STORE: begin
            ram_we    = 1'b1;
            ram_waddr = wi_ff;
            ram_wdata = stored;
            dry_in    = $signed({1'b0, dry_w}) * x_ff;
            state_in  = ST_MIX;
         end
         ST_MIX: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = mixed;
               wi_in         = wi_ff + 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         wi_ff         <= '0;
         lfo_phase_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         wi_ff         <= wi_in;
         lfo_phase_ff  <= lfo_phase_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         step_ff  <= '0;
         fbk_ff   <= '0;
         wet_ff   <= WET_RESET;
      end else if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_DEPTH: depth_ff <= csr_wdata[DEPTH_W-1:0];
            CSR_STEP:  step_ff  <= csr_wdata[STEP_W-1:0];
            CSR_FBK:   fbk_ff   <= csr_wdata[FBK_W-1:0];
            CSR_WET:   wet_ff   <= csr_wdata[WET_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      quad_ff      <= quad_in;
      z_ff         <= z_in;
      z2_ff        <= z2_in;
      r1_ff        <= r1_in;
      r2_ff        <= r2_in;
      y_ff         <= y_in;
      delay_ff     <= delay_in;
      ib_ff        <= ib_in;
      frac_ff      <= frac_in;
      acc_ff       <= acc_in;
      dly_ff       <= dly_in;
      fbp_ff       <= fbp_in;
      dry_ff       <= dry_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // no input transfer while the ring is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("input ready during ring clear");

   a_accept_starts_seq: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_Z2))
      else $error("accepted sample did not start the sequence");

   a_wi_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX && out_free) |=> (wi_ff == AW'($past(wi_ff) + 1'b1)))
      else $error("write index did not advance after result");

   a_result_from_mix: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == ST_MIX))
      else $error("result raised outside the mix step");

   a_single_ring_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE) |=> !ram_we)
      else $error("ring written twice for one sample");

endmodule

`default_nettype wire
